>>> sv/compacting_key_value_table_defines.svh
// assertion macros for the compacting key-value table
`ifndef COMPACTING_KEY_VALUE_TABLE_DEFINES_SVH
`define COMPACTING_KEY_VALUE_TABLE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define KVT_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define KVT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/kvt_pkg.sv
package kvt_pkg;

	localparam int CMD_W       = 2;
	localparam int KEY_W       = 64;
	localparam int VALUE_W     = 32;
	localparam int COUNT_OUT_W = 5;

	localparam int DEF_ENTRIES  = 16;
	localparam int DEF_KEY_BITS = 64;

	// command queue between front and back, power of two
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
	localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

	typedef enum logic [1:0] {
		OP_SET,
		OP_GET,
		OP_DEL,
		OP_NOP
	} op_kind_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SRCH,
		B_SHIFT
	} back_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic [KEY_W-1:0]          key;
		logic signed [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic                      found;
		logic [COUNT_OUT_W-1:0]    entry_count;
		logic                      status;
	} result_t;

	// classified operation as it sits in the queue
	typedef struct packed {
		op_kind_t                  kind;
		logic [KEY_W-1:0]          key;
		logic signed [VALUE_W-1:0] value;
	} op_t;

endpackage

>>> sv/kvt_front.sv
module kvt_front #(
	parameter int KEY_BITS = kvt_pkg::DEF_KEY_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  kvt_pkg::item_t  item,
	output logic            q_valid,
	input  logic            q_pop,
	output kvt_pkg::op_t    q_op
);
	import kvt_pkg::*;

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
	localparam logic [QW:0] FULL = (QW + 1)'(QUEUE_DEPTH);

	op_t             fifo_q [QUEUE_DEPTH];
	logic [QW-1:0]   wr_ptr_q;
	logic [QW-1:0]   rd_ptr_q;
	logic [QW:0]     fill_q;
	logic            push;
	op_t             op_in;

	// decode the command and trim the key to the stored width
	always_comb begin
		op_in.key   = item.key & KEY_MASK;
		op_in.value = item.value;
		case (item.cmd)
			CMD_SET: op_in.kind = OP_SET;
			CMD_GET: op_in.kind = OP_GET;
			CMD_DEL: op_in.kind = OP_DEL;
			default: op_in.kind = OP_NOP;
		endcase
	end

	assign busy    = (fill_q == FULL);
	assign push    = start && !busy;
	assign q_valid = (fill_q != '0);
	assign q_op    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QW'(1);
			end
			fill_q <= fill_q + (QW + 1)'(push) - (QW + 1)'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= op_in;
		end
	end

endmodule

>>> sv/kvt_back.sv
module kvt_back #(
	parameter int ENTRIES  = kvt_pkg::DEF_ENTRIES,
	parameter int KEY_BITS = kvt_pkg::DEF_KEY_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  kvt_pkg::op_t      q_op,
	output logic              done,
	output kvt_pkg::result_t  result
);
	import kvt_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [CW-1:0] CNT_MAX = CW'(ENTRIES);

	logic [KEY_BITS-1:0] key_mem [ENTRIES];
	logic [VALUE_W-1:0]  val_mem [ENTRIES];

	back_state_t         state_q, state_d;
	op_t                 cur_q;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       rd_idx_q, rd_idx_d;
	logic                vld_s1;
	logic [AW-1:0]       idx_s1;
	logic [KEY_BITS-1:0] key_s1;
	logic [VALUE_W-1:0]  val_s1;
	logic                done_q;
	result_t             result_q;

	op_t                 op_w;
	logic                rd_en;
	logic                key_we, val_we;
	logic [AW-1:0]       wr_addr;
	logic [KEY_BITS-1:0] wr_key;
	logic [VALUE_W-1:0]  wr_val;
	logic                emit;
	result_t             res_d;
	logic                hit, last;

	assign op_w = (state_q == B_IDLE) ? q_op : cur_q;
	assign hit  = vld_s1 && (key_s1 == cur_q.key[KEY_BITS-1:0]);
	assign last = vld_s1 && ((CW'(idx_s1) + CW'(1)) == count_q);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		q_pop    = 1'b0;
		rd_en    = 1'b0;
		rd_idx_d = rd_idx_q;
		key_we   = 1'b0;
		val_we   = 1'b0;
		wr_addr  = idx_s1;
		wr_key   = key_s1;
		wr_val   = val_s1;
		emit     = 1'b0;
		res_d.read_value = '0;
		res_d.found      = 1'b0;
		res_d.status     = 1'b0;

		case (state_q)
			B_IDLE: begin
				rd_idx_d = '0;
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_op.kind == OP_NOP || count_q == '0) begin
						emit = 1'b1;
					end else begin
						state_d = B_SRCH;
					end
				end
			end
			B_SRCH: begin
				rd_en    = (rd_idx_q < count_q);
				rd_idx_d = rd_idx_q + CW'(rd_en);
				if (hit) begin
					res_d.found = 1'b1;
					case (cur_q.kind)
						OP_GET: begin
							res_d.read_value = val_s1;
							emit    = 1'b1;
							state_d = B_IDLE;
						end
						OP_SET: begin
							val_we  = 1'b1;
							wr_val  = cur_q.value;
							emit    = 1'b1;
							state_d = B_IDLE;
						end
						OP_DEL: begin
							if (last) begin
								count_d = count_q - CW'(1);
								emit    = 1'b1;
								state_d = B_IDLE;
							end else begin
								state_d = B_SHIFT;
							end
						end
						default: begin
							emit    = 1'b1;
							state_d = B_IDLE;
						end
					endcase
				end else if (last) begin
					emit    = 1'b1;
					state_d = B_IDLE;
				end
			end
			B_SHIFT: begin
				// read slot j+2 while writing the previous read, slot j+1, into slot j
				rd_en    = (rd_idx_q < count_q);
				rd_idx_d = rd_idx_q + CW'(rd_en);
				if (vld_s1) begin
					key_we  = 1'b1;
					val_we  = 1'b1;
					wr_addr = idx_s1 - AW'(1);
					if (last) begin
						count_d     = count_q - CW'(1);
						res_d.found = 1'b1;
						emit        = 1'b1;
						state_d     = B_IDLE;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase

		// miss on a set appends at the tail, or is refused when full
		if (emit && !res_d.found && op_w.kind == OP_SET) begin
			if (count_q < CNT_MAX) begin
				key_we  = 1'b1;
				val_we  = 1'b1;
				wr_addr = count_q[AW-1:0];
				wr_key  = op_w.key[KEY_BITS-1:0];
				wr_val  = op_w.value;
				count_d = count_q + CW'(1);
			end else begin
				res_d.status = 1'b1;
			end
		end
		res_d.entry_count = COUNT_OUT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			rd_idx_q <= rd_idx_d;
			vld_s1   <= rd_en;
			done_q   <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_op;
		end
		if (rd_en) begin
			idx_s1 <= rd_idx_q[AW-1:0];
		end
		if (emit) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (val_we) begin
			val_mem[wr_addr] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			key_s1 <= key_mem[rd_idx_q[AW-1:0]];
			val_s1 <= val_mem[rd_idx_q[AW-1:0]];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> sv/compacting_key_value_table.sv
// compacting key-value table: up to ENTRIES keys, each with a 32-bit value,
// kept packed in slots 0 to count-1. a command beat is taken when start is
// high and busy is low; busy only rises when the two-deep command queue is
// full. each command gives exactly one result beat, a single-cycle pulse on
// done that cannot be held off, in command order. a command leaves the
// queue, then the key store is scanned one slot per cycle through its
// single registered read port; a delete then moves every later entry down
// at one slot per cycle, which ends at the same point a miss would. the
// engine takes the next command from the queue only once it is back in
// idle, and a command on an empty table or an unused code is answered
// without a scan. there is no clearing pass after reset.
`include "compacting_key_value_table_defines.svh"

module compacting_key_value_table #(
	parameter int ENTRIES  = kvt_pkg::DEF_ENTRIES,
	parameter int KEY_BITS = kvt_pkg::DEF_KEY_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kvt_pkg::item_t    item,
	output logic              done,
	output kvt_pkg::result_t  result
);
	import kvt_pkg::*;

	// queue handoff between the decode side and the table engine
	logic q_valid;
	logic q_pop;
	op_t  q_op;

	// front: decode commands, mask keys, buffer up to two beats
	kvt_front #(
		.KEY_BITS (KEY_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_op    (q_op)
	);

	// back: scan, update, append and compact the table, one result beat each
	kvt_back #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_op    (q_op),
		.done    (done),
		.result  (result)
	);

	// a refused set only happens with a full table and never reports a value
	`KVT_ASSERT_IMPL(a_refused_full, done && result.status, result.entry_count == COUNT_OUT_W'(ENTRIES) && result.read_value == '0, "refused set without full table")
	// a miss never returns data
	`KVT_ASSERT_IMPL(a_miss_zero, done && !result.found, result.read_value == '0, "miss returned nonzero value")
	// a matched key is never refused
	`KVT_ASSERT_ALWAYS(a_hit_not_refused, !(done && result.found && result.status), "hit flagged as refused")

endmodule

>>> tb/compacting_key_value_table_tb.sv
module compacting_key_value_table_tb;
	import kvt_pkg::*;

	localparam int ENTRIES  = DEF_ENTRIES;
	localparam int KEY_BITS = DEF_KEY_BITS;
	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

	// the package names three commands; the fourth code does nothing
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	// worst item is a full scan plus the result register, with some slack
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
	localparam int POOL_KEYS    = 20;
	localparam int RANDOM_BEATS = 1000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;

	compacting_key_value_table u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// one row of the directed table: a command beat, and optionally the
	// result typed in by hand instead of taken from the shadow table
	typedef struct {
		item_t   beat;
		bit      typed;
		result_t want;
	} stim_row_t;

	stim_row_t directed_rows[$];

	// shadow copy of the table, packed in slots 0 to shadow_count-1
	logic [KEY_W-1:0]          shadow_keys [ENTRIES];
	logic signed [VALUE_W-1:0] shadow_values [ENTRIES];
	int                        shadow_count;

	result_t          pending_results[$];
	logic [KEY_W-1:0] key_pool [POOL_KEYS];
	int               mismatches;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop far beyond the slowest legal run
	initial begin
		#4000000;
		$display("compacting_key_value_table verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// applies one command to the shadow table and returns its result beat
	function automatic result_t table_result(input item_t beat);
		result_t          r;
		logic [KEY_W-1:0] k;
		int               slot;
		int               i;
		r    = '0;
		k    = beat.key & KEY_MASK;
		slot = -1;
		for (i = 0; i < shadow_count; i++) begin
			if (slot < 0 && shadow_keys[i] == k)
				slot = i;
		end
		r.found = (slot >= 0);
		case (beat.cmd)
			CMD_SET: begin
				if (slot >= 0) begin
					shadow_values[slot] = beat.value;
				end else if (shadow_count < ENTRIES) begin
					shadow_keys[shadow_count]   = k;
					shadow_values[shadow_count] = beat.value;
					shadow_count++;
				end else begin
					// new key into a full table is refused
					r.status = 1'b1;
				end
			end
			CMD_GET: begin
				if (slot >= 0)
					r.read_value = shadow_values[slot];
			end
			CMD_DEL: begin
				if (slot >= 0) begin
					// close the gap so the list stays packed
					for (i = slot; i + 1 < shadow_count; i++) begin
						shadow_keys[i]   = shadow_keys[i + 1];
						shadow_values[i] = shadow_values[i + 1];
					end
					shadow_count--;
				end
			end
			default: begin
				r.found = 1'b0;
			end
		endcase
		r.entry_count = shadow_count[COUNT_OUT_W-1:0];
		return r;
	endfunction

	task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
			input logic [VALUE_W-1:0] value, input bit typed,
			input logic [VALUE_W-1:0] rd, input bit hit, input int cnt, input bit st);
		stim_row_t row;
		row.beat.cmd         = cmd;
		row.beat.key         = key;
		row.beat.value       = value;
		row.typed            = typed;
		row.want.read_value  = rd;
		row.want.found       = hit;
		row.want.entry_count = cnt[COUNT_OUT_W-1:0];
		row.want.status      = st;
		directed_rows.push_back(row);
	endtask

	// random command beat; mostly keys from a small pool so sets, hits and
	// deletes land on held entries, with some fully random keys as noise
	function automatic item_t random_beat(input bit draining);
		item_t beat;
		int    pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			beat.cmd = CMD_NONE;
		else if (pick < (draining ? 30 : 60))
			beat.cmd = CMD_SET;
		else if (pick < (draining ? 55 : 85))
			beat.cmd = CMD_GET;
		else
			beat.cmd = CMD_DEL;
		if ($urandom_range(0, 9) == 0)
			beat.key = {$urandom, $urandom};
		else
			beat.key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
		case ($urandom_range(0, 9))
			0:       beat.value = 32'h7fff_ffff;
			1:       beat.value = 32'h8000_0000;
			default: beat.value = $urandom;
		endcase
		return beat;
	endfunction

	// sender gap of random length, inserted with a chance of pct percent
	task automatic sender_gap(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	endtask

	// holds the beat until an edge sees start high and busy low, then files
	// the expected result; start is left high for the caller to decide
	task automatic send_beat(input item_t beat, input bit typed, input result_t want);
		result_t predicted;
		start <= 1'b1;
		item  <= beat;
		do
			@(posedge clk);
		while (busy);
		predicted = table_result(beat);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// result beats are single-cycle pulses, checked in command order
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat", 64'(result), 64'(0));
			end else begin
				want = pending_results.pop_front();
				if (result.read_value !== want.read_value)
					report_mismatch("read_value", 64'(result.read_value),
						64'(want.read_value));
				if (result.found !== want.found)
					report_mismatch("found", 64'(result.found), 64'(want.found));
				if (result.entry_count !== want.entry_count)
					report_mismatch("entry_count", 64'(result.entry_count),
						64'(want.entry_count));
				if (result.status !== want.status)
					report_mismatch("status", 64'(result.status), 64'(want.status));
			end
		end
	end

	initial begin
		int      i;
		int      phase;
		int      n;
		int      pct;
		bit      draining;
		result_t none;

		arst_n       = 1'b0;
		start        = 1'b0;
		item         = '0;
		mismatches   = 0;
		shadow_count = 0;
		none         = '0;

		// pool keeps both extreme keys and enough others to overfill the table
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (i = 2; i < POOL_KEYS; i++)
			key_pool[i] = {$urandom, $urandom};

		// empty table: misses and the unused code
		add_row(CMD_GET,  64'h0, 32'h0, 1, 32'h0, 0, 0, 0);
		add_row(CMD_DEL,  64'h0, 32'h0, 1, 32'h0, 0, 0, 0);
		add_row(CMD_NONE, '1,    '1,    1, 32'h0, 0, 0, 0);
		// extreme keys with extreme values
		add_row(CMD_SET,  64'h0, 32'h7fff_ffff, 1, 32'h0, 0, 1, 0);
		add_row(CMD_SET,  '1,    32'h8000_0000, 1, 32'h0, 0, 2, 0);
		add_row(CMD_GET,  64'h0, 32'h0, 1, 32'h7fff_ffff, 1, 2, 0);
		add_row(CMD_GET,  '1,    32'h0, 1, 32'h8000_0000, 1, 2, 0);
		// update in place keeps the count
		add_row(CMD_SET,  64'h0, 32'hffff_ffff, 1, 32'h0, 1, 2, 0);
		// fill to capacity with walking-nibble keys
		for (i = 1; i <= ENTRIES - 2; i++)
			add_row(CMD_SET, 64'(i) << (4 * i - 4), 32'(i * 32'h0101_0101), 1, 32'h0, 0, i + 2, 0);
		// full table: new key refused, held key still updated
		add_row(CMD_SET,  64'hdead_beef_cafe_f00d, 32'h5a5a_5a5a, 1, 32'h0, 0, ENTRIES, 1);
		add_row(CMD_SET,  64'h7 << 24, 32'h0000_1234, 1, 32'h0, 1, ENTRIES, 0);
		// top bit alone must not match key zero
		add_row(CMD_GET,  64'h8000_0000_0000_0000, 32'h0, 1, 32'h0, 0, ENTRIES, 0);
		// delete from slot zero shifts the whole table down
		add_row(CMD_DEL,  64'h0, 32'h0, 1, 32'h0, 1, ENTRIES - 1, 0);
		add_row(CMD_GET,  64'h7 << 24, 32'h0, 0, 32'h0, 0, 0, 0);
		add_row(CMD_DEL,  '1, 32'h0, 1, 32'h0, 1, ENTRIES - 2, 0);
		// delete of the last slot moves nothing
		add_row(CMD_DEL,  64'he << 52, 32'h0, 0, 32'h0, 0, 0, 0);
		add_row(CMD_GET,  '1, 32'h0, 1, 32'h0, 0, ENTRIES - 3, 0);
		add_row(CMD_NONE, 64'h3 << 8, 32'h1, 1, 32'h0, 0, ENTRIES - 3, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			sender_gap(6);
			send_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);
		end

		// three idling phases: light gaps, heavy gaps, back to back; within
		// each, every stretch of 50 beats randomly fills or drains the table
		draining = 1'b0;
		for (phase = 0; phase < 3; phase++) begin
			pct = (phase == 0) ? 6 : (phase == 1) ? 48 : 0;
			for (n = 0; n < RANDOM_BEATS / 3 + 1; n++) begin
				if (n % 50 == 0)
					draining = $urandom_range(0, 1);
				sender_gap(pct);
				send_beat(random_beat(draining), 0, none);
			end
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		// catch any stray beat after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("compacting_key_value_table verification clean");
		else
			$display("compacting_key_value_table verification failed");
		$finish;
	end

endmodule
